/* src/similarity_transform_fit_macros.svh */
// Assertion helpers used by the similarity fit RTL.
// Each macro expects clk and arst_n in scope.
`ifndef SIMILARITY_TRANSFORM_FIT_MACROS_SVH
`define SIMILARITY_TRANSFORM_FIT_MACROS_SVH

// Same-cycle implication.
`define STF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define STF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/stf_pkg.sv */
package stf_pkg;

	localparam int MAX_POINTS_DEF = 128;

	localparam int COORD_W = 24;
	localparam int SUM_W   = 32;
	localparam int MOM_W   = 56;
	localparam int WIDE_W  = 64;
	localparam int RES_W   = 32;
	localparam int OPND_W  = 33;
	localparam int PROD_W  = 66;
	localparam int PC_W    = 5;

	// fit status codes
	localparam logic [1:0] FIT_OK       = 2'd0;
	localparam logic [1:0] FIT_SINGULAR = 2'd1;
	localparam logic [1:0] FIT_OVERFLOW = 2'd2;

	// first micro-op of each program
	localparam logic [PC_W-1:0] PC_ACC   = 5'd0;
	localparam logic [PC_W-1:0] PC_SOLVE = 5'd9;
	localparam logic [PC_W-1:0] PC_TRAN  = 5'd24;

	// multiplier A operand sources
	localparam logic [3:0] A_SX = 4'd0;
	localparam logic [3:0] A_SY = 4'd1;
	localparam logic [3:0] A_TX = 4'd2;
	localparam logic [3:0] A_TY = 4'd3;
	localparam logic [3:0] A_W  = 4'd4;
	localparam logic [3:0] A_X1 = 4'd5;
	localparam logic [3:0] A_Y1 = 4'd6;
	localparam logic [3:0] A_X2 = 4'd7;
	localparam logic [3:0] A_Y2 = 4'd8;
	localparam logic [3:0] A_CA = 4'd9;
	localparam logic [3:0] A_CB = 4'd10;

	// multiplier B operand sources
	localparam logic [3:0] B_SX   = 4'd0;
	localparam logic [3:0] B_SY   = 4'd1;
	localparam logic [3:0] B_ZLO  = 4'd2;
	localparam logic [3:0] B_ZHI  = 4'd3;
	localparam logic [3:0] B_C1LO = 4'd4;
	localparam logic [3:0] B_C1HI = 4'd5;
	localparam logic [3:0] B_C2LO = 4'd6;
	localparam logic [3:0] B_C2HI = 4'd7;
	localparam logic [3:0] B_X2   = 4'd8;
	localparam logic [3:0] B_Y2   = 4'd9;
	localparam logic [3:0] B_K16  = 4'd10;

	// accumulator write-back targets
	localparam logic [2:0] D_NORM  = 3'd0;
	localparam logic [2:0] D_DOT   = 3'd1;
	localparam logic [2:0] D_CROSS = 3'd2;
	localparam logic [2:0] D_DEN   = 3'd3;
	localparam logic [2:0] D_NA    = 3'd4;
	localparam logic [2:0] D_NB    = 3'd5;

	typedef struct packed {
		logic [3:0] a_sel;
		logic [3:0] b_sel;
		logic       first;  // start accumulator from the product
		logic       sh;     // product weighted by 2^28
		logic       neg;    // subtract the product
		logic       wr;     // write accumulator back, no product
		logic [2:0] dest;
		logic       stop;   // last micro-op of the program
	} mac_op_t;

	typedef struct packed {
		logic start;
		logic frac;   // 16 fraction bits in the quotient
	} div_ctl_t;

	function automatic mac_op_t mul_op(input logic [3:0] a, input logic [3:0] b,
			input logic first, input logic sh, input logic neg);
		mac_op_t op;
		op = '0;
		op.a_sel = a;
		op.b_sel = b;
		op.first = first;
		op.sh    = sh;
		op.neg   = neg;
		return op;
	endfunction

	function automatic mac_op_t wr_op(input logic [2:0] dest, input logic stop);
		mac_op_t op;
		op = '0;
		op.wr   = 1'b1;
		op.dest = dest;
		op.stop = stop;
		return op;
	endfunction

	// micro-op programs: per-pair moments, normal equations, translation numerators
	function automatic mac_op_t op_rom(input logic [PC_W-1:0] pc);
		mac_op_t op;
		unique case (pc)
			5'd0:  op = mul_op(A_SX, B_SX,   1'b1, 1'b0, 1'b0);
			5'd1:  op = mul_op(A_SY, B_SY,   1'b0, 1'b0, 1'b0);
			5'd2:  op = wr_op(D_NORM, 1'b0);
			5'd3:  op = mul_op(A_TX, B_SX,   1'b1, 1'b0, 1'b0);
			5'd4:  op = mul_op(A_TY, B_SY,   1'b0, 1'b0, 1'b0);
			5'd5:  op = wr_op(D_DOT, 1'b0);
			5'd6:  op = mul_op(A_TY, B_SX,   1'b1, 1'b0, 1'b0);
			5'd7:  op = mul_op(A_TX, B_SY,   1'b0, 1'b0, 1'b1);
			5'd8:  op = wr_op(D_CROSS, 1'b1);
			5'd9:  op = mul_op(A_W,  B_ZLO,  1'b1, 1'b0, 1'b0);
			5'd10: op = mul_op(A_W,  B_ZHI,  1'b0, 1'b1, 1'b0);
			5'd11: op = mul_op(A_X2, B_X2,   1'b0, 1'b0, 1'b1);
			5'd12: op = mul_op(A_Y2, B_Y2,   1'b0, 1'b0, 1'b1);
			5'd13: op = wr_op(D_DEN, 1'b0);
			5'd14: op = mul_op(A_W,  B_C1LO, 1'b1, 1'b0, 1'b0);
			5'd15: op = mul_op(A_W,  B_C1HI, 1'b0, 1'b1, 1'b0);
			5'd16: op = mul_op(A_X1, B_X2,   1'b0, 1'b0, 1'b1);
			5'd17: op = mul_op(A_Y1, B_Y2,   1'b0, 1'b0, 1'b1);
			5'd18: op = wr_op(D_NA, 1'b0);
			5'd19: op = mul_op(A_W,  B_C2LO, 1'b1, 1'b0, 1'b0);
			5'd20: op = mul_op(A_W,  B_C2HI, 1'b0, 1'b1, 1'b0);
			5'd21: op = mul_op(A_Y1, B_X2,   1'b0, 1'b0, 1'b1);
			5'd22: op = mul_op(A_X1, B_Y2,   1'b0, 1'b0, 1'b0);
			5'd23: op = wr_op(D_NB, 1'b1);
			5'd24: op = mul_op(A_X1, B_K16,  1'b1, 1'b0, 1'b0);
			5'd25: op = mul_op(A_CA, B_X2,   1'b0, 1'b0, 1'b1);
			5'd26: op = mul_op(A_CB, B_Y2,   1'b0, 1'b0, 1'b0);
			5'd27: op = wr_op(D_NA, 1'b0);
			5'd28: op = mul_op(A_Y1, B_K16,  1'b1, 1'b0, 1'b0);
			5'd29: op = mul_op(A_CB, B_X2,   1'b0, 1'b0, 1'b1);
			5'd30: op = mul_op(A_CA, B_Y2,   1'b0, 1'b0, 1'b1);
			5'd31: op = wr_op(D_NB, 1'b1);
			default: op = '0;
		endcase
		return op;
	endfunction

endpackage

/* src/stf_div.sv */
module stf_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stf_pkg::div_ctl_t       ctl,
	input  logic signed [63:0]      num,
	input  logic [63:0]             den,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      quo
);
	import stf_pkg::*;

	localparam int DVD_W = WIDE_W + 16;
	localparam int CNT_W = $clog2(DVD_W);

	logic               busy_q, fin_q, done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [WIDE_W:0]    rem_q;
	logic [33:0]        quo_q;
	logic               sticky_q, neg_q;
	logic [WIDE_W-1:0]  den_q;
	logic signed [31:0] res_q;

	logic [WIDE_W-1:0]  mag;
	logic [WIDE_W:0]    rem_sh;
	logic               ge;
	logic               up;
	logic [34:0]        qr;
	logic signed [31:0] res_d;

	always_comb begin
		mag    = num[63] ? WIDE_W'(-num) : WIDE_W'(num);
		rem_sh = {rem_q[WIDE_W-1:0], dvd_q[DVD_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		up     = {rem_q, 1'b0} >= {2'b00, den_q};
		qr     = 35'(quo_q) + 35'(up);
		if (neg_q) begin
			if (sticky_q || qr >= 35'h080000000)
				res_d = 32'sh80000000;
			else
				res_d = -$signed(qr[31:0]);
		end else begin
			if (sticky_q || qr > 35'h07FFFFFFF)
				res_d = 32'sh7FFFFFFF;
			else
				res_d = $signed(qr[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q && !fin_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// restoring long division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q && !fin_q) begin
			dvd_q    <= ctl.frac ? {mag, 16'h0000} : {16'h0000, mag};
			rem_q    <= '0;
			quo_q    <= '0;
			sticky_q <= 1'b0;
			neg_q    <= num[63];
			den_q    <= den;
		end else if (busy_q) begin
			rem_q    <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q    <= {quo_q[32:0], ge};
			sticky_q <= sticky_q | quo_q[33];
			dvd_q    <= dvd_q << 1;
		end
		if (fin_q)
			res_q <= res_d;
	end

	assign busy = busy_q | fin_q;
	assign done = done_q;
	assign quo  = res_q;

endmodule

/* src/similarity_transform_fit.sv */
// Channel   Dir  Handshake                  Payload
// pairs     in   s_axis_tvalid/tready       s_axis_tdata, s_axis_tlast = last_pair
// results   out  m_axis_tvalid/tready       m_axis_tdata, m_axis_tuser = fit_status
//
// An accepted pair runs nine micro-ops through the shared 33x33 multiply-accumulate unit,
// then a drain state before the next ready; a dropped pair goes straight to the drain state.
// A marked pair adds the solve: 23 micro-ops and four divisions on the bit-serial divider
// (fewer on a singular fit, none after an overflow) before the result is requested.
// arst_n clears all sums, the pair count, the overflow flag and both valids.
// A stalled result sits in the output register; the next set of pairs still enters.
`include "similarity_transform_fit_macros.svh"
module similarity_transform_fit #(
	parameter int MAX_POINTS = stf_pkg::MAX_POINTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [95:0]   s_axis_tdata,   // target_x, target_y, source_x, source_y
	input  logic          s_axis_tlast,   // last_pair
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [127:0]  m_axis_tdata,   // scale_cos, scale_sin, shift_x, shift_y
	output logic [1:0]    m_axis_tuser    // fit_status
);
	import stf_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ACC    = 4'd1;
	localparam logic [3:0] S_ACCW   = 4'd2;
	localparam logic [3:0] S_SOLVE  = 4'd3;
	localparam logic [3:0] S_SOLVEW = 4'd4;
	localparam logic [3:0] S_DIVA   = 4'd5;
	localparam logic [3:0] S_DIVB   = 4'd6;
	localparam logic [3:0] S_TRAN   = 4'd7;
	localparam logic [3:0] S_TRANW  = 4'd8;
	localparam logic [3:0] S_DIVX   = 4'd9;
	localparam logic [3:0] S_DIVY   = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	logic [3:0]             state_q;
	logic [PC_W-1:0]        pc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   ovf_q, last_q;

	// running sums
	logic signed [SUM_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [MOM_W-1:0] norm_q, dot_q, cross_q;

	// current pair
	logic signed [COORD_W-1:0] tx_q, ty_q, sx_q, sy_q;

	// solve intermediates and results
	logic signed [WIDE_W-1:0] den_q, na_q, nb_q, acc_q;
	logic signed [RES_W-1:0]  ca_q, cb_q, px_q, py_q;
	logic [1:0]               status_q;

	// output register
	logic          mv_q;
	logic [127:0]  mdata_q;
	logic [1:0]    muser_q;

	// shared multiply-accumulate unit
	mac_op_t                  cur_op, op_s1;
	logic                     issue, v_s1;
	logic signed [OPND_W-1:0] a_opnd, b_opnd;
	logic signed [PROD_W-1:0] prod, p_s1;
	logic [WIDE_W-1:0]        term;
	logic [WIDE_W-1:0]        acc_next;

	// divider hookup
	div_ctl_t                 div_ctl;
	logic signed [WIDE_W-1:0] div_num;
	logic [WIDE_W-1:0]        div_den, wden;
	logic                     div_busy, div_done;
	logic signed [RES_W-1:0]  div_quo;

	logic s_acc, in_full, den_le0, out_load;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign in_full       = cnt_q >= CNT_W'(MAX_POINTS);
	assign den_le0       = den_q <= 64'sd0;
	assign out_load      = (state_q == S_OUT) && (!mv_q || m_axis_tready);
	assign wden          = WIDE_W'(cnt_q) << 16;

	// operand selection for the shared multiplier
	always_comb begin
		cur_op = op_rom(pc_q);
		issue  = (state_q == S_ACC) || (state_q == S_SOLVE) || (state_q == S_TRAN);
		unique case (cur_op.a_sel)
			A_SX:    a_opnd = OPND_W'(sx_q);
			A_SY:    a_opnd = OPND_W'(sy_q);
			A_TX:    a_opnd = OPND_W'(tx_q);
			A_TY:    a_opnd = OPND_W'(ty_q);
			A_W:     a_opnd = $signed(OPND_W'(cnt_q));
			A_X1:    a_opnd = OPND_W'(x1_q);
			A_Y1:    a_opnd = OPND_W'(y1_q);
			A_X2:    a_opnd = OPND_W'(x2_q);
			A_Y2:    a_opnd = OPND_W'(y2_q);
			A_CA:    a_opnd = OPND_W'(ca_q);
			A_CB:    a_opnd = OPND_W'(cb_q);
			default: a_opnd = '0;
		endcase
		// wide moments split into an unsigned low 28 bits and a signed high part
		unique case (cur_op.b_sel)
			B_SX:    b_opnd = OPND_W'(sx_q);
			B_SY:    b_opnd = OPND_W'(sy_q);
			B_ZLO:   b_opnd = $signed({5'b00000, norm_q[27:0]});
			B_ZHI:   b_opnd = OPND_W'($signed(norm_q[MOM_W-1:28]));
			B_C1LO:  b_opnd = $signed({5'b00000, dot_q[27:0]});
			B_C1HI:  b_opnd = OPND_W'($signed(dot_q[MOM_W-1:28]));
			B_C2LO:  b_opnd = $signed({5'b00000, cross_q[27:0]});
			B_C2HI:  b_opnd = OPND_W'($signed(cross_q[MOM_W-1:28]));
			B_X2:    b_opnd = OPND_W'(x2_q);
			B_Y2:    b_opnd = OPND_W'(y2_q);
			B_K16:   b_opnd = 33'sd65536;
			default: b_opnd = '0;
		endcase
		prod = a_opnd * b_opnd;
	end

	// accumulate stage: all arithmetic is modulo 2^64, the final values fit
	always_comb begin
		term     = op_s1.sh ? (p_s1[WIDE_W-1:0] << 28) : p_s1[WIDE_W-1:0];
		acc_next = (op_s1.first ? '0 : acc_q) + (op_s1.neg ? -term : term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		p_s1  <= prod;
		op_s1 <= cur_op;
		if (v_s1 && !op_s1.wr)
			acc_q <= acc_next;
		if (v_s1 && op_s1.wr) begin
			unique case (op_s1.dest)
				D_DEN:   den_q <= acc_q;
				D_NA:    na_q  <= acc_q;
				D_NB:    nb_q  <= acc_q;
				default: ;
			endcase
		end
	end

	// divider requests: a and b over the denominator, then translations over W*2^16
	always_comb begin
		div_ctl.start = (state_q == S_SOLVEW && !den_le0) ||
			(state_q == S_DIVA && div_done) ||
			(state_q == S_TRANW) ||
			(state_q == S_DIVX && div_done);
		div_ctl.frac  = (state_q == S_SOLVEW) || (state_q == S_DIVA);
		div_num       = (state_q == S_SOLVEW || state_q == S_TRANW) ? na_q : nb_q;
		div_den       = div_ctl.frac ? den_q : wden;
	end

	stf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer, sums and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= PC_ACC;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			x1_q    <= '0;
			y1_q    <= '0;
			x2_q    <= '0;
			y2_q    <= '0;
			norm_q  <= '0;
			dot_q   <= '0;
			cross_q <= '0;
			mv_q    <= 1'b0;
		end else begin
			// raise on a new result, drop once taken
			if (out_load)
				mv_q <= 1'b1;
			else if (mv_q && m_axis_tready)
				mv_q <= 1'b0;

			// fold the per-pair moments into the sums
			if (v_s1 && op_s1.wr) begin
				unique case (op_s1.dest)
					D_NORM:  norm_q  <= norm_q  + acc_q[MOM_W-1:0];
					D_DOT:   dot_q   <= dot_q   + acc_q[MOM_W-1:0];
					D_CROSS: cross_q <= cross_q + acc_q[MOM_W-1:0];
					default: ;
				endcase
			end

			if (issue)
				pc_q <= pc_q + 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						last_q <= s_axis_tlast;
						if (in_full) begin
							// drop the pair, remember the overflow
							ovf_q   <= 1'b1;
							state_q <= S_ACCW;
						end else begin
							x1_q    <= x1_q + SUM_W'($signed(s_axis_tdata[23:0]));
							y1_q    <= y1_q + SUM_W'($signed(s_axis_tdata[47:24]));
							x2_q    <= x2_q + SUM_W'($signed(s_axis_tdata[71:48]));
							y2_q    <= y2_q + SUM_W'($signed(s_axis_tdata[95:72]));
							cnt_q   <= cnt_q + 1'b1;
							pc_q    <= PC_ACC;
							state_q <= S_ACC;
						end
					end
				end
				S_ACC: begin
					if (cur_op.stop)
						state_q <= S_ACCW;
				end
				S_ACCW: begin
					if (!last_q)
						state_q <= S_IDLE;
					else if (ovf_q)
						state_q <= S_OUT;
					else begin
						pc_q    <= PC_SOLVE;
						state_q <= S_SOLVE;
					end
				end
				S_SOLVE: begin
					if (cur_op.stop)
						state_q <= S_SOLVEW;
				end
				S_SOLVEW: begin
					state_q <= den_le0 ? S_OUT : S_DIVA;
				end
				S_DIVA: begin
					if (div_done)
						state_q <= S_DIVB;
				end
				S_DIVB: begin
					if (div_done) begin
						pc_q    <= PC_TRAN;
						state_q <= S_TRAN;
					end
				end
				S_TRAN: begin
					if (cur_op.stop)
						state_q <= S_TRANW;
				end
				S_TRANW: begin
					state_q <= S_DIVX;
				end
				S_DIVX: begin
					if (div_done)
						state_q <= S_DIVY;
				end
				S_DIVY: begin
					if (div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						// hand over the result, clear the set
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						x1_q    <= '0;
						y1_q    <= '0;
						x2_q    <= '0;
						y2_q    <= '0;
						norm_q  <= '0;
						dot_q   <= '0;
						cross_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pair capture, coefficients and output payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			tx_q <= s_axis_tdata[23:0];
			ty_q <= s_axis_tdata[47:24];
			sx_q <= s_axis_tdata[71:48];
			sy_q <= s_axis_tdata[95:72];
		end
		if (state_q == S_ACCW && last_q && ovf_q) begin
			status_q <= FIT_OVERFLOW;
			ca_q     <= '0;
			cb_q     <= '0;
			px_q     <= '0;
			py_q     <= '0;
		end
		if (state_q == S_SOLVEW) begin
			status_q <= den_le0 ? FIT_SINGULAR : FIT_OK;
			ca_q     <= '0;
			cb_q     <= '0;
			px_q     <= '0;
			py_q     <= '0;
		end
		if (div_done) begin
			unique case (state_q)
				S_DIVA:  ca_q <= div_quo;
				S_DIVB:  cb_q <= div_quo;
				S_DIVX:  px_q <= div_quo;
				S_DIVY:  py_q <= div_quo;
				default: ;
			endcase
		end
		if (out_load) begin
			mdata_q <= {py_q, px_q, cb_q, ca_q};
			muser_q <= status_q;
		end
	end

	assign m_axis_tvalid = mv_q;
	assign m_axis_tdata  = mdata_q;
	assign m_axis_tuser  = muser_q;

	`STF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_POINTS), "pair count above limit")
	`STF_ASSERT_NEXT(a_clear_after_out, out_load, cnt_q == '0 && !ovf_q && norm_q == '0, "sums not cleared")
	`STF_ASSERT_NOW(a_fail_zero, m_axis_tvalid && m_axis_tuser != FIT_OK, m_axis_tdata == '0, "failed fit carries data")
	`STF_ASSERT_NOW(a_div_idle, div_ctl.start, !div_busy, "divider request while busy")

endmodule

/* tb/tb.sv */
module tb;
	import stf_pkg::*;

	localparam int MAXP = 128;
	localparam longint CYCLE_LIMIT = 64'd3000000;

	typedef struct packed {
		logic [31:0] scale_cos;
		logic [31:0] scale_sin;
		logic [31:0] shift_x;
		logic [31:0] shift_y;
		logic [1:0]  fit_status;
	} fit_result_t;

	// Least-squares similarity predictor: running moments, solve on the last pair.
	class fit_scoreboard;
		longint sum_tx, sum_ty, sum_sx, sum_sy, sum_norm, sum_dot, sum_cross;
		int count;
		bit overflow;
		fit_result_t pending[$];
		int errors;

		function void clear();
			sum_tx = 0; sum_ty = 0; sum_sx = 0; sum_sy = 0;
			sum_norm = 0; sum_dot = 0; sum_cross = 0;
			count = 0; overflow = 0;
		endfunction

		// round(num * 2^frac / den), ties away from zero, saturated to 32 bits
		function logic [31:0] div_round(longint num, longint unsigned den, int frac);
			bit neg;
			longint unsigned mag, q, r;
			neg = num < 0;
			mag = neg ? 64'd0 - num : num;
			q = mag / den;
			r = mag % den;
			if (q >= 64'h1_0000_0000) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
			for (int i = 0; i < frac; i++) begin
				q = q << 1;
				r = r << 1;
				if (r >= den) begin
					r -= den;
					q |= 1;
				end
			end
			if (r >= den - r) q++;
			if (neg) begin
				if (q >= 64'h8000_0000) return 32'h8000_0000;
				return 32'(-longint'(q));
			end
			if (q > 64'h7fff_ffff) return 32'h7fff_ffff;
			return q[31:0];
		endfunction

		function void note_pair(logic [95:0] data, bit last);
			longint tx, ty, sx, sy, w, d, na, nb;
			fit_result_t res;
			tx = longint'($signed(data[23:0]));
			ty = longint'($signed(data[47:24]));
			sx = longint'($signed(data[71:48]));
			sy = longint'($signed(data[95:72]));
			if (count >= MAXP) overflow = 1;
			else begin
				sum_tx += tx; sum_ty += ty; sum_sx += sx; sum_sy += sy;
				sum_norm += sx * sx + sy * sy;
				sum_dot += tx * sx + ty * sy;
				sum_cross += ty * sx - tx * sy;
				count++;
			end
			if (!last) return;
			res = '0;
			if (overflow) res.fit_status = FIT_OVERFLOW;
			else begin
				w = count;
				d = w * sum_norm - sum_sx * sum_sx - sum_sy * sum_sy;
				if (d <= 0) res.fit_status = FIT_SINGULAR;
				else begin
					res.fit_status = FIT_OK;
					na = w * sum_dot - sum_tx * sum_sx - sum_ty * sum_sy;
					nb = w * sum_cross - sum_ty * sum_sx + sum_tx * sum_sy;
					res.scale_cos = div_round(na, d, 16);
					res.scale_sin = div_round(nb, d, 16);
					res.shift_x = div_round(sum_tx * 65536
						- longint'($signed(res.scale_cos)) * sum_sx
						+ longint'($signed(res.scale_sin)) * sum_sy, w << 16, 0);
					res.shift_y = div_round(sum_ty * 65536
						- longint'($signed(res.scale_sin)) * sum_sx
						- longint'($signed(res.scale_cos)) * sum_sy, w << 16, 0);
				end
			end
			pending = {pending, res};
			clear();
		endfunction

		function void check_result(logic [127:0] data, logic [1:0] status);
			fit_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result tdata=%h tuser=%0d", $time, data, status);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (data[31:0] !== exp_r.scale_cos) begin
				$display("%0t: scale_cos exp %h got %h", $time, exp_r.scale_cos, data[31:0]);
				errors++;
			end
			if (data[63:32] !== exp_r.scale_sin) begin
				$display("%0t: scale_sin exp %h got %h", $time, exp_r.scale_sin, data[63:32]);
				errors++;
			end
			if (data[95:64] !== exp_r.shift_x) begin
				$display("%0t: shift_x exp %h got %h", $time, exp_r.shift_x, data[95:64]);
				errors++;
			end
			if (data[127:96] !== exp_r.shift_y) begin
				$display("%0t: shift_y exp %h got %h", $time, exp_r.shift_y, data[127:96]);
				errors++;
			end
			if (status !== exp_r.fit_status) begin
				$display("%0t: fit_status exp %0d got %0d", $time, exp_r.fit_status, status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;   // target_x, target_y, source_x, source_y
	logic s_axis_tlast = 0;           // last_pair
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [127:0] m_axis_tdata;       // scale_cos, scale_sin, shift_x, shift_y
	logic [1:0] m_axis_tuser;         // fit_status

	fit_scoreboard board = new();
	longint cycles = 0;
	bit hold_off = 0;
	bit long_hold_done = 0;

	always #4 clk = ~clk;

	similarity_transform_fit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Watchdog: fail the run if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Sample both handshakes at the edge; requests feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_pair(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Receiver: random stalls, plus one long hold-off while pairs keep coming.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) m_axis_tready <= 0;
			else if (m_axis_tready && m_axis_tvalid) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
				if (gap > 0) begin
					m_axis_tready <= 0;
					repeat (gap) @(posedge clk);
				end
				m_axis_tready <= 1;
			end else m_axis_tready <= 1;
		end
	end

	// Pick a coordinate: extremes, small values or anything in range.
	function automatic logic [23:0] pick_coord(int mode);
		case (mode)
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 4000)) - 24'd2000;
			default: return 24'($urandom);
		endcase
	endfunction

	// Offer one pair and hold it until the block takes it.
	task automatic send_pair(logic [23:0] tx, logic [23:0] ty, logic [23:0] sx,
			logic [23:0] sy, bit last, bit idle);
		int gap;
		gap = idle ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19)) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {sy, sx, ty, tx};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Random set of n pairs; a mostly similarity-mapped set gives well-posed fits.
	task automatic send_set(int n, bit idle);
		int mode, a, b, ox, oy;
		logic [23:0] sx, sy;
		mode = $urandom_range(0, 3);
		a = $urandom_range(0, 1024) - 512;
		b = $urandom_range(0, 1024) - 512;
		ox = $urandom_range(0, 200000) - 100000;
		oy = $urandom_range(0, 200000) - 100000;
		for (int i = 0; i < n; i++) begin
			if (mode <= 1) begin
				sx = 24'($urandom_range(0, 40000)) - 24'd20000;
				sy = 24'($urandom_range(0, 40000)) - 24'd20000;
				send_pair(24'((a * $signed(sx) - b * $signed(sy)) / 256 + ox
					+ int'($urandom_range(0, 8))),
					24'((b * $signed(sx) + a * $signed(sy)) / 256 + oy
					+ int'($urandom_range(0, 8))), sx, sy, i == n - 1, idle);
			end else
				send_pair(pick_coord($urandom_range(0, 5)), pick_coord($urandom_range(0, 5)),
					pick_coord($urandom_range(0, 5)), pick_coord($urandom_range(0, 5)),
					i == n - 1, idle);
		end
	endtask

	initial begin
		int sent, n;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: single pair (singular), identical points, extremes, pure shift.
		send_pair(24'h000100, 24'h000200, 24'h000300, 24'h000400, 1, 0);
		send_pair(24'h000100, 24'h000100, 24'h000500, 24'h000500, 0, 0);
		send_pair(24'h000100, 24'h000100, 24'h000500, 24'h000500, 1, 0);
		send_pair(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 0, 0);
		send_pair(24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 0, 0);
		send_pair(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 1, 0);
		send_pair(24'h000a00, 24'h000b00, 24'h000000, 24'h000000, 0, 0);
		send_pair(24'h000b00, 24'h000b00, 24'h000100, 24'h000000, 0, 0);
		send_pair(24'h000a00, 24'h000c00, 24'h000000, 24'h000100, 1, 0);
		// Tiny source spread, huge targets: saturates a and b.
		send_pair(24'h7fffff, 24'h800000, 24'h000000, 24'h000000, 0, 0);
		send_pair(24'h800000, 24'h7fffff, 24'h000001, 24'h000000, 1, 0);
		sent = 11;

		// Overflow: 130 pairs, and a set of exactly the maximum.
		send_set(MAXP + 2, 1);
		send_set(MAXP, 1);
		sent += 2 * MAXP + 2;

		// Long receiver hold-off while several sets go in.
		fork
			begin
				hold_off = 1;
				repeat (6000) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int k = 0; k < 6; k++) send_set($urandom_range(2, 4), 0);
			end
		join
		sent += 18;

		while (sent < 1850) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 135)
				: $urandom_range(1, 12);
			send_set(n, $urandom_range(0, 4) != 0);
			sent += n;
		end
		s_axis_tvalid <= 0;
		s_axis_tlast <= 0;

		while (board.pending.size() > 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+src
src/stf_pkg.sv
src/stf_div.sv
src/similarity_transform_fit.sv
tb/tb.sv
